FILE: hw/rtl/cftl_pkg.sv
package cftl_pkg;

  typedef enum logic [3:0] {
    CODE_OK          = 4'd0,
    CODE_OVERCURRENT = 4'd1,
    CODE_RMS_LOW     = 4'd2,
    CODE_RMS_HIGH    = 4'd3,
    CODE_FREQ_LOW    = 4'd4,
    CODE_FREQ_HIGH   = 4'd5,
    CODE_DRIVER      = 4'd6,
    CODE_STOPPED     = 4'd7,
    CODE_DC_LOW      = 4'd8,
    CODE_DC_HIGH     = 4'd9
  } code_t;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_DC_MIN        = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DC_MAX        = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CURRENT_LIMIT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RMS_MIN       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RMS_MAX       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FREQ_MIN      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FREQ_MAX      = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_FOUR_WIRE     = 3'd7;

  typedef struct packed {
    logic signed [15:0] dc_min;
    logic signed [15:0] dc_max;
    logic [14:0]        current_limit;
    logic [15:0]        rms_min;
    logic [15:0]        rms_max;
    logic signed [15:0] freq_min;
    logic signed [15:0] freq_max;
    logic               four_wire;
  } cfg_t;

  typedef struct packed {
    logic               start_req;
    logic               gate_fault;
    logic signed [15:0] v_dc;
    logic signed [15:0] i_a;
    logic signed [15:0] i_b;
    logic signed [15:0] i_c;
    logic signed [15:0] i_neutral;
    logic [15:0]        rms_a;
    logic [15:0]        rms_b;
    logic [15:0]        rms_c;
    logic signed [15:0] omega;
  } meas_t;

  // |x| saturated to 15 bits
  function automatic logic [14:0] mag15(input logic signed [15:0] x);
    logic [15:0] neg;
    begin
      neg = 16'(-x);
      if (!x[15]) begin
        mag15 = x[14:0];
      end else if (neg[15]) begin
        mag15 = 15'h7fff;
      end else begin
        mag15 = neg[14:0];
      end
    end
  endfunction

endpackage

FILE: hw/rtl/converter_fault_trip_latch_unit.sv
// Each request passes an input register, then a result register.
// Throughput: one request per cycle unless stalled; latch updates with result.
// Stall on the result side backs up into the input register, then asserts in_stall.
// Reset (rst_n low, synchronous): both stages empty, latched code no fault,
// driver reset request clear, configuration registers to their defaults.
module converter_fault_trip_latch_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_req,
  input  logic                          in_gate_fault,
  input  logic signed [15:0]            in_v_dc,
  input  logic signed [15:0]            in_i_a,
  input  logic signed [15:0]            in_i_b,
  input  logic signed [15:0]            in_i_c,
  input  logic signed [15:0]            in_i_neutral,
  input  logic [15:0]                   in_rms_a,
  input  logic [15:0]                   in_rms_b,
  input  logic [15:0]                   in_rms_c,
  input  logic signed [15:0]            in_omega,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_pwm_enable,
  output logic [3:0]                    out_fault_code,
  output logic                          out_reset_drivers,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cftl_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cftl_pkg::CfgDataW-1:0] cfg_wdata
);

  cftl_pkg::cfg_t  cfg;
  cftl_pkg::meas_t meas_r;
  cftl_pkg::code_t run_code;
  cftl_pkg::code_t lat_code_r;
  cftl_pkg::code_t code_nxt;
  logic            lat_rst_r;
  logic            rst_nxt;
  logic            pwm_nxt;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic            out_free;
  logic            s1_move;
  logic            in_take;
  logic            pwm_r;
  logic [3:0]      code_r;
  logic            rdrv_r;

  assign cfg_ready = 1'b1;

  cftl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cftl_chk u_chk (
    .meas     (meas_r),
    .cfg      (cfg),
    .run_code (run_code)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    pwm_nxt  = 1'b0;
    code_nxt = lat_code_r;
    rst_nxt  = lat_rst_r;
    if (meas_r.start_req && lat_code_r == cftl_pkg::CODE_OK) begin
      code_nxt = run_code;
      rst_nxt  = (run_code == cftl_pkg::CODE_DRIVER);
      pwm_nxt  = (run_code == cftl_pkg::CODE_OK);
    end else if (!meas_r.start_req) begin
      code_nxt = cftl_pkg::CODE_STOPPED;
      rst_nxt  = 1'b0;
    end else if (lat_code_r == cftl_pkg::CODE_STOPPED) begin
      // re-arm, gates stay off for this request
      code_nxt = cftl_pkg::CODE_OK;
      rst_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lat_code_r  <= cftl_pkg::CODE_OK;
      lat_rst_r   <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        lat_code_r <= code_nxt;
        lat_rst_r  <= rst_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      meas_r.start_req    <= in_start_req;
      meas_r.gate_fault   <= in_gate_fault;
      meas_r.v_dc         <= in_v_dc;
      meas_r.i_a          <= in_i_a;
      meas_r.i_b          <= in_i_b;
      meas_r.i_c          <= in_i_c;
      meas_r.i_neutral    <= in_i_neutral;
      meas_r.rms_a        <= in_rms_a;
      meas_r.rms_b        <= in_rms_b;
      meas_r.rms_c        <= in_rms_c;
      meas_r.omega        <= in_omega;
    end
    if (s1_move) begin
      pwm_r  <= pwm_nxt;
      code_r <= code_nxt;
      rdrv_r <= rst_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pwm_enable    = pwm_r;
  assign out_fault_code    = code_r;
  assign out_reset_drivers = rdrv_r;

endmodule

FILE: hw/rtl/cftl_cfg.sv
module cftl_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [cftl_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [cftl_pkg::CfgDataW-1:0]     cfg_wdata,
  output cftl_pkg::cfg_t                    cfg
);

  cftl_pkg::cfg_t cfg_r;
  cftl_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        cftl_pkg::REG_DC_MIN:        cfg_nxt.dc_min        = cfg_wdata;
        cftl_pkg::REG_DC_MAX:        cfg_nxt.dc_max        = cfg_wdata;
        cftl_pkg::REG_CURRENT_LIMIT: cfg_nxt.current_limit = cfg_wdata[14:0];
        cftl_pkg::REG_RMS_MIN:       cfg_nxt.rms_min       = cfg_wdata;
        cftl_pkg::REG_RMS_MAX:       cfg_nxt.rms_max       = cfg_wdata;
        cftl_pkg::REG_FREQ_MIN:      cfg_nxt.freq_min      = cfg_wdata;
        cftl_pkg::REG_FREQ_MAX:      cfg_nxt.freq_max      = cfg_wdata;
        cftl_pkg::REG_FOUR_WIRE:     cfg_nxt.four_wire     = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dc_min        <= 16'sd0;
      cfg_r.dc_max        <= 16'sh7fff;
      cfg_r.current_limit <= 15'h7fff;
      cfg_r.rms_min       <= 16'h0000;
      cfg_r.rms_max       <= 16'hffff;
      cfg_r.freq_min      <= 16'sd0;
      cfg_r.freq_max      <= 16'sh7fff;
      cfg_r.four_wire     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/cftl_chk.sv
module cftl_chk (
  input  cftl_pkg::meas_t  meas,
  input  cftl_pkg::cfg_t   cfg,
  output cftl_pkg::code_t  run_code
);

  logic [14:0] mag_a;
  logic [14:0] mag_b;
  logic [14:0] mag_c;
  logic        dc_lo;
  logic        dc_hi;
  logic        oc_phase;
  logic        rms_lo;
  logic        rms_hi;
  logic        fr_lo;
  logic        fr_hi;
  logic        oc_neu;

  assign mag_a = cftl_pkg::mag15(meas.i_a);
  assign mag_b = cftl_pkg::mag15(meas.i_b);
  assign mag_c = cftl_pkg::mag15(meas.i_c);

  assign dc_lo    = !(meas.v_dc > cfg.dc_min);
  assign dc_hi    = !(meas.v_dc < cfg.dc_max);
  assign oc_phase = !(mag_a < cfg.current_limit && mag_b < cfg.current_limit &&
                      mag_c < cfg.current_limit);
  assign rms_lo   = !(meas.rms_a > cfg.rms_min && meas.rms_b > cfg.rms_min &&
                      meas.rms_c > cfg.rms_min);
  assign rms_hi   = !(meas.rms_a < cfg.rms_max && meas.rms_b < cfg.rms_max &&
                      meas.rms_c < cfg.rms_max);
  assign fr_lo    = !(meas.omega > cfg.freq_min);
  assign fr_hi    = !(meas.omega < cfg.freq_max);
  // negative neutral current never trips
  assign oc_neu   = cfg.four_wire && !meas.i_neutral[15] &&
                    !(meas.i_neutral[14:0] < cfg.current_limit);

  always_comb begin
    if (dc_lo) begin
      run_code = cftl_pkg::CODE_DC_LOW;
    end else if (dc_hi) begin
      run_code = cftl_pkg::CODE_DC_HIGH;
    end else if (oc_phase) begin
      run_code = cftl_pkg::CODE_OVERCURRENT;
    end else if (rms_lo) begin
      run_code = cftl_pkg::CODE_RMS_LOW;
    end else if (rms_hi) begin
      run_code = cftl_pkg::CODE_RMS_HIGH;
    end else if (fr_lo) begin
      run_code = cftl_pkg::CODE_FREQ_LOW;
    end else if (fr_hi) begin
      run_code = cftl_pkg::CODE_FREQ_HIGH;
    end else if (meas.gate_fault) begin
      run_code = cftl_pkg::CODE_DRIVER;
    end else if (oc_neu) begin
      run_code = cftl_pkg::CODE_OVERCURRENT;
    end else begin
      run_code = cftl_pkg::CODE_OK;
    end
  end

endmodule

FILE: tb/trip_scoreboard.sv
`timescale 1ns / 100ps

package trip_sb_pkg;
  import cftl_pkg::*;

  typedef struct {
    logic  pwm;
    code_t code;
    logic  rst;
  } trip_result_t;

  class trip_scoreboard;
    int dc_lo, dc_hi, i_limit, rms_lo, rms_hi, w_lo, w_hi;
    bit neutral_check;
    code_t held_code;
    logic held_rst;
    trip_result_t expected_q[$];
    int mismatches;

    function new();
      dc_lo = 0;
      dc_hi = 32767;
      i_limit = 32767;
      rms_lo = 0;
      rms_hi = 65535;
      w_lo = 0;
      w_hi = 32767;
      neutral_check = 1'b0;
      held_code = CODE_OK;
      held_rst = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_DC_MIN:        dc_lo = $signed(data);
        REG_DC_MAX:        dc_hi = $signed(data);
        REG_CURRENT_LIMIT: i_limit = data[14:0];
        REG_RMS_MIN:       rms_lo = data;
        REG_RMS_MAX:       rms_hi = data;
        REG_FREQ_MIN:      w_lo = $signed(data);
        REG_FREQ_MAX:      w_hi = $signed(data);
        REG_FOUR_WIRE:     neutral_check = data[0];
        default: ;
      endcase
    endfunction

    function int sat_mag(int x);
      if (x < 0) x = -x;
      return (x > 32767) ? 32767 : x;
    endfunction

    // first failing window wins
    function code_t trip_check(meas_t m);
      int vdc, w, neu, ia, ib, ic, ra, rb, rc;
      vdc = $signed(m.v_dc);
      w = $signed(m.omega);
      neu = $signed(m.i_neutral);
      ia = sat_mag($signed(m.i_a));
      ib = sat_mag($signed(m.i_b));
      ic = sat_mag($signed(m.i_c));
      ra = m.rms_a;
      rb = m.rms_b;
      rc = m.rms_c;
      if (!(vdc > dc_lo)) return CODE_DC_LOW;
      if (!(vdc < dc_hi)) return CODE_DC_HIGH;
      if (!(ia < i_limit && ib < i_limit && ic < i_limit)) return CODE_OVERCURRENT;
      if (!(ra > rms_lo && rb > rms_lo && rc > rms_lo)) return CODE_RMS_LOW;
      if (!(ra < rms_hi && rb < rms_hi && rc < rms_hi)) return CODE_RMS_HIGH;
      if (!(w > w_lo)) return CODE_FREQ_LOW;
      if (!(w < w_hi)) return CODE_FREQ_HIGH;
      if (m.gate_fault) return CODE_DRIVER;
      if (neutral_check && !(neu < i_limit)) return CODE_OVERCURRENT;
      return CODE_OK;
    endfunction

    function void note_request(meas_t m);
      trip_result_t r;
      r.pwm = 1'b0;
      if (m.start_req && held_code == CODE_OK) begin
        r.code = trip_check(m);
        r.rst = (r.code == CODE_DRIVER);
        r.pwm = (r.code == CODE_OK);
      end else if (!m.start_req) begin
        r.code = CODE_STOPPED;
        r.rst = 1'b0;
      end else if (held_code == CODE_STOPPED) begin
        r.code = CODE_OK;
        r.rst = 1'b0;
      end else begin
        r.code = held_code;
        r.rst = held_rst;
      end
      held_code = r.code;
      held_rst = r.rst;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic pwm, logic [3:0] code, logic rst);
      trip_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: pwm %b code %0d rst %b",
                   $realtime, pwm, code, rst);
        return;
      end
      e = expected_q.pop_front();
      if (pwm !== e.pwm || code !== e.code || rst !== e.rst) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected pwm %b code %0d rst %b, got pwm %b code %0d rst %b",
                   $realtime, e.pwm, e.code, e.rst, pwm, code, rst);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int failures();
      return mismatches + expected_q.size();
    endfunction
  endclass

endpackage

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cftl_pkg::*;
  import trip_sb_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 110;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_start_req = 1'b0;
  logic in_gate_fault = 1'b0;
  logic signed [15:0] in_v_dc = '0;
  logic signed [15:0] in_i_a = '0;
  logic signed [15:0] in_i_b = '0;
  logic signed [15:0] in_i_c = '0;
  logic signed [15:0] in_i_neutral = '0;
  logic [15:0] in_rms_a = '0;
  logic [15:0] in_rms_b = '0;
  logic [15:0] in_rms_c = '0;
  logic signed [15:0] in_omega = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_pwm_enable;
  logic [3:0] out_fault_code;
  logic out_reset_drivers;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  trip_scoreboard sb = new();
  cfg_t cur_cfg;
  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  converter_fault_trip_latch_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_pwm_enable, out_fault_code, out_reset_drivers);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the pipe
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_DC_MIN, c.dc_min);
    write_reg(REG_DC_MAX, c.dc_max);
    write_reg(REG_CURRENT_LIMIT, {1'($urandom), c.current_limit});
    write_reg(REG_RMS_MIN, c.rms_min);
    write_reg(REG_RMS_MAX, c.rms_max);
    write_reg(REG_FREQ_MIN, c.freq_min);
    write_reg(REG_FREQ_MAX, c.freq_max);
    write_reg(REG_FOUR_WIRE, {15'($urandom), c.four_wire});
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic send_meas(input meas_t m);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(4, 1) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= m.start_req;
    in_gate_fault <= m.gate_fault;
    in_v_dc <= m.v_dc;
    in_i_a <= m.i_a;
    in_i_b <= m.i_b;
    in_i_c <= m.i_c;
    in_i_neutral <= m.i_neutral;
    in_rms_a <= m.rms_a;
    in_rms_b <= m.rms_b;
    in_rms_c <= m.rms_c;
    in_omega <= m.omega;
    do @(posedge clk); while (in_stall);
    sb.note_request(m);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // all fields inside the directed windows; negative neutral
  function automatic meas_t nominal_meas();
    return '{1'b1, 1'b0, 16'd15000, 16'd1000, 16'hfc18, 16'd500, 16'h8000,
             16'd20000, 16'd20000, 16'd20000, 16'd300};
  endfunction

  // stop, re-arm, then the tripping request
  task automatic rearm_and_send(input meas_t m);
    meas_t idle_m;
    idle_m = nominal_meas();
    idle_m.start_req = 1'b0;
    send_meas(idle_m);
    idle_m.start_req = 1'b1;
    send_meas(idle_m);
    send_meas(m);
  endtask

  // mode 0: strictly inside the window (anything if it is too narrow), 1: edges mixed in, 2: anything
  function automatic int pick_field(int lo, int hi, int floor_v, int ceil_v, int mode);
    int r;
    int v;
    r = $urandom_range(99);
    if (mode == 2 || hi - lo <= 1 || (mode == 1 && r < 15))
      return floor_v + int'($urandom_range(ceil_v - floor_v));
    if (mode == 0 || r < 55)
      return lo + 1 + int'($urandom_range(hi - lo - 2));
    case (r % 6)
      0: v = lo;
      1: v = hi;
      2: v = lo + 1;
      3: v = hi - 1;
      4: v = floor_v;
      default: v = ceil_v;
    endcase
    if (v < floor_v) v = floor_v;
    if (v > ceil_v) v = ceil_v;
    return v;
  endfunction

  function automatic meas_t make_item();
    meas_t m;
    int r;
    int mode;
    int lim;
    r = $urandom_range(99);
    mode = (r < 65) ? 0 : (r < 90) ? 1 : 2;
    lim = cur_cfg.current_limit;
    m.start_req = ($urandom_range(99) >= 10);
    m.gate_fault = (mode == 0) ? 1'b0 : ($urandom_range(2) == 0);
    m.v_dc = 16'(pick_field($signed(cur_cfg.dc_min), $signed(cur_cfg.dc_max),
                            -32768, 32767, mode));
    m.i_a = 16'(pick_field(-lim, lim, -32768, 32767, mode));
    m.i_b = 16'(pick_field(-lim, lim, -32768, 32767, mode));
    m.i_c = 16'(pick_field(-lim, lim, -32768, 32767, mode));
    m.i_neutral = 16'(pick_field(-32769, cur_cfg.four_wire ? lim : 32768,
                                 -32768, 32767, mode));
    m.rms_a = 16'(pick_field(cur_cfg.rms_min, cur_cfg.rms_max, 0, 65535, mode));
    m.rms_b = 16'(pick_field(cur_cfg.rms_min, cur_cfg.rms_max, 0, 65535, mode));
    m.rms_c = 16'(pick_field(cur_cfg.rms_min, cur_cfg.rms_max, 0, 65535, mode));
    m.omega = 16'(pick_field($signed(cur_cfg.freq_min), $signed(cur_cfg.freq_max),
                             -32768, 32767, mode));
    return m;
  endfunction

  function automatic void pick_bounds(input int floor_v, input int ceil_v,
                                      output int lo, output int hi);
    int t;
    lo = floor_v + int'($urandom_range(ceil_v - floor_v));
    hi = floor_v + int'($urandom_range(ceil_v - floor_v));
    if (lo > hi && $urandom_range(4) != 0) begin
      t = lo;
      lo = hi;
      hi = t;
    end
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    int lo, hi;
    pick_bounds(-32768, 32767, lo, hi);
    c.dc_min = 16'(lo);
    c.dc_max = 16'(hi);
    pick_bounds(0, 65535, lo, hi);
    c.rms_min = 16'(lo);
    c.rms_max = 16'(hi);
    pick_bounds(-32768, 32767, lo, hi);
    c.freq_min = 16'(lo);
    c.freq_max = 16'(hi);
    case ($urandom_range(3))
      0: c.current_limit = '0;
      1: c.current_limit = 15'h7fff;
      default: c.current_limit = 15'($urandom);
    endcase
    c.four_wire = 1'($urandom);
    return c;
  endfunction

  initial begin
    meas_t m;
    cfg_t c;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    apply_settings('{16'd100, 16'd30000, 15'd20000, 16'd1000, 16'd50000,
                     16'hff9c, 16'd1000, 1'b1});
    m = nominal_meas();
    send_meas(m);
    m.v_dc = cur_cfg.dc_min;
    send_meas(m);
    m = nominal_meas();
    m.v_dc = cur_cfg.dc_max;
    rearm_and_send(m);
    m = nominal_meas();
    m.i_b = 16'h8000;
    rearm_and_send(m);
    m = nominal_meas();
    m.rms_c = cur_cfg.rms_min;
    rearm_and_send(m);
    m = nominal_meas();
    m.rms_a = cur_cfg.rms_max;
    rearm_and_send(m);
    m = nominal_meas();
    m.omega = cur_cfg.freq_min;
    rearm_and_send(m);
    m = nominal_meas();
    m.omega = cur_cfg.freq_max;
    rearm_and_send(m);
    m = nominal_meas();
    m.gate_fault = 1'b1;
    rearm_and_send(m);
    send_meas(nominal_meas());
    m = nominal_meas();
    m.i_neutral = 16'(cur_cfg.current_limit);
    rearm_and_send(m);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: c = '{16'h0000, 16'h7fff, 15'h7fff, 16'h0000, 16'hffff,
                 16'h0000, 16'h7fff, 1'b0};
        1: c = '{16'h8000, 16'h7fff, 15'h7fff, 16'h0000, 16'hffff,
                 16'h8000, 16'h7fff, 1'b1};
        7: c = '{16'h7fff, 16'h8000, 15'h0000, 16'hffff, 16'h0000,
                 16'h7fff, 16'h8000, 1'b1};
        default: c = random_cfg();
      endcase
      apply_settings(c);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 52; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 30) hold_off = 1'b1;
        send_meas(make_item());
      end
      wait_idle();
    end

    if (sb.failures() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
